// ===== src/audio_pause_shortener_unit_assert.svh =====
// Assertion macros used by the checker file of the pause shortener.
`ifndef AUDIO_PAUSE_SHORTENER_UNIT_ASSERT_SVH
`define AUDIO_PAUSE_SHORTENER_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define APSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define APSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/apsu_pkg.sv =====
// Shared types and constants of the audio pause shortener.
`timescale 1ns / 1ps

package apsu_pkg;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_IDLE   = 1'b1
  } opcode_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SILENCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd2;

  localparam logic [14:0] SILENCE_RESET   = 15'd327;
  localparam logic [15:0] THRESHOLD_RESET = 16'd3200;
  localparam logic [16:0] SCALE_ONE       = 17'h10000;

  // Per-transaction outcome handed from the control logic to the output stage.
  typedef struct packed {
    logic valid;
    logic cend;
    logic ovf;
    logic fwd;
  } item_flags_t;

endpackage

// ===== src/apsu_ring.sv =====
// Sample ring memory: one write port and one registered read port.
`timescale 1ns / 1ps

module apsu_ring #(
  parameter int RING_DEPTH  = 16384,
  parameter int PTR_W       = 14,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [PTR_W-1:0]       waddr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  input  logic                   re,
  input  logic [PTR_W-1:0]       raddr,
  output logic [SAMPLE_BITS-1:0] rdata
);

  logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/apsu_ctrl.sv =====
// Pointer, run and fill bookkeeping; issues at most one ring write and at most one ring read per transaction.
`timescale 1ns / 1ps

module apsu_ctrl #(
  parameter int RING_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 16,
  parameter int PTR_W       = 14,
  parameter int FC_W        = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [apsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apsu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           accept,
  input  logic                           opcode,
  input  logic [SAMPLE_BITS-1:0]         sample_in,
  input  logic                           clip_last,
  output logic                           ring_we,
  output logic [PTR_W-1:0]               ring_waddr,
  output logic [SAMPLE_BITS-1:0]         ring_wdata,
  output logic                           ring_re,
  output logic [PTR_W-1:0]               ring_raddr,
  output apsu_pkg::item_flags_t          flags
);

  import apsu_pkg::*;

  localparam int PROD_W = FC_W + 17;

  logic [14:0]      silence_level;
  logic [15:0]      pause_threshold;
  logic [16:0]      pause_scale;
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [FC_W-1:0]  fill_count, fill_count_next;
  logic [PTR_W-1:0] run_start, run_start_next;
  logic [FC_W-1:0]  run_length, run_length_next;
  logic             in_quiet_run, in_quiet_run_next;
  logic             end_pending, end_pending_next;

  logic                   is_sample, full, store, quiet, loud, mag_le;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   close_loud, close_last, close_any, cut_en;
  logic                   iq_after, ep_after, rd, cend;
  logic [FC_W-1:0]        rl_after, rl_c, keep, fc_mid, committed;
  logic [PTR_W-1:0]       rs_eff, cut_wp, waddr;
  logic [16:0]            scale_eff;
  logic [PROD_W-1:0]      prod;

  // Add modulo the ring depth; both operands are at most the depth.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [FC_W-1:0] k);
    logic [FC_W:0] sum;
    sum = (FC_W+1)'(p) + (FC_W+1)'(k);
    if (sum >= (FC_W+1)'(RING_DEPTH)) begin
      sum = sum - (FC_W+1)'(RING_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  always_comb begin
    is_sample = accept && (opcode == OP_SAMPLE);
    full      = fill_count >= FC_W'(RING_DEPTH);
    store     = is_sample && !full;
    mag       = sample_in[SAMPLE_BITS-1] ? (~sample_in + 1'b1) : sample_in;
    mag_le    = 32'(mag) <= 32'(silence_level);
    quiet     = store && mag_le;
    loud      = store && !mag_le;

    close_loud = loud && in_quiet_run;
    rl_after   = quiet ? (in_quiet_run ? run_length + 1'b1 : FC_W'(1)) : run_length;
    iq_after   = quiet || (in_quiet_run && !loud);
    rs_eff     = (quiet && !in_quiet_run) ? write_pointer : run_start;
    close_last = is_sample && clip_last && iq_after;
    close_any  = close_loud || close_last;

    // A run ended by a loud sample is cut at the threshold; one ended by the
    // clip end only above it.
    rl_c   = close_loud ? run_length : rl_after;
    cut_en = close_any && (close_loud ? (32'(run_length) >= 32'(pause_threshold))
                                      : (32'(rl_after) > 32'(pause_threshold)));

    scale_eff = (pause_scale > SCALE_ONE) ? SCALE_ONE : pause_scale;
    prod      = PROD_W'(rl_c) * PROD_W'(scale_eff);
    keep      = prod[FC_W+15:16];
    cut_wp    = ring_add(rs_eff, keep);

    waddr = (close_loud && cut_en) ? cut_wp : write_pointer;
    if (close_last && cut_en) begin
      write_pointer_next = cut_wp;
    end else if (store) begin
      write_pointer_next = ring_add(waddr, FC_W'(1));
    end else begin
      write_pointer_next = write_pointer;
    end

    fc_mid            = fill_count + FC_W'(store) - (cut_en ? rl_c - keep : '0);
    run_length_next   = close_any ? '0 : rl_after;
    in_quiet_run_next = close_any ? 1'b0 : iq_after;
    run_start_next    = rs_eff;

    committed = fc_mid - (in_quiet_run_next ? run_length_next : '0);
    rd        = accept && (committed != '0);

    fill_count_next   = fc_mid - FC_W'(rd);
    read_pointer_next = rd ? ring_add(read_pointer, FC_W'(1)) : read_pointer;

    ep_after         = end_pending || (is_sample && clip_last);
    cend             = accept && ep_after && (fill_count_next == '0);
    end_pending_next = ep_after && !cend;
  end

  assign ring_we    = store;
  assign ring_waddr = waddr;
  assign ring_wdata = sample_in;
  assign ring_re    = rd;
  assign ring_raddr = read_pointer;

  always_comb begin
    flags.valid = rd;
    flags.cend  = cend;
    flags.ovf   = is_sample && full;
    // The sample written in this transaction is also the one read out.
    flags.fwd   = rd && store && (read_pointer == waddr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_level   <= SILENCE_RESET;
      pause_threshold <= THRESHOLD_RESET;
      pause_scale     <= SCALE_ONE;
      write_pointer   <= '0;
      read_pointer    <= '0;
      fill_count      <= '0;
      run_start       <= '0;
      run_length      <= '0;
      in_quiet_run    <= 1'b0;
      end_pending     <= 1'b0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      fill_count    <= fill_count_next;
      run_start     <= run_start_next;
      run_length    <= run_length_next;
      in_quiet_run  <= in_quiet_run_next;
      end_pending   <= end_pending_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SILENCE:   silence_level   <= cfg_data[14:0];
          REG_THRESHOLD: pause_threshold <= cfg_data[15:0];
          REG_SCALE:     pause_scale     <= cfg_data[16:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/audio_pause_shortener_unit.sv =====
// Top level of the audio pause shortener: ring, control and output stage.
//
// Samples enter on the s_ channel: s_tdata carries the sample, s_tuser the
// opcode (sample or idle tick) and s_tlast the last-of-clip mark. Every input
// transaction yields exactly one result on the m_ channel: m_tdata carries the
// drained sample (zero when none), m_tuser the sample-valid and overflow flags,
// and m_tlast the end-of-clip mark. Quiet samples wait in a ring memory until
// their run is decided; long pauses are cut to the configured fraction.
// One transaction is taken every cycle while s_tready is high: each uses the
// single ring write port and the single ring read port at most once, and the
// run-length scale multiply sits in that cycle. Reset clears pointers, counts
// and run state and loads the register defaults; the ring needs no clearing,
// since only stored entries are read. When m_tready is low the result holds
// in the output register, one more result waits in the read stage, and s_tready
// drops until space frees up. Registers are written through cfg_we, cfg_index
// and cfg_data, by the user only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module audio_pause_shortener_unit #(
  parameter int RING_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [apsu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [apsu_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // sample_in
  input  logic                                 s_tuser,  // opcode
  input  logic                                 s_tlast,  // clip_last
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // sample_out
  output logic [1:0]                           m_tuser,  // sample_valid, overflow
  output logic                                 m_tlast   // clip_end
);

  import apsu_pkg::*;

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int FC_W    = $clog2(RING_DEPTH + 1);
  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  logic                   accept, s1_adv;
  logic                   ring_we, ring_re;
  logic [PTR_W-1:0]       ring_waddr, ring_raddr;
  logic [SAMPLE_BITS-1:0] ring_wdata, ring_rdata;
  item_flags_t            flags;

  logic                   s1_v;
  item_flags_t            s1_flags;
  logic [SAMPLE_BITS-1:0] s1_fwd_data;
  logic                   out_v;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic                   out_valid_bit, out_cend, out_ovf;

  assign s1_adv   = !out_v || m_tready;
  assign s_tready = !s1_v || s1_adv;
  assign accept   = s_tvalid && s_tready;

  apsu_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .PTR_W      (PTR_W),
    .FC_W       (FC_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .opcode    (s_tuser),
    .sample_in (s_tdata[SAMPLE_BITS-1:0]),
    .clip_last (s_tlast),
    .ring_we   (ring_we),
    .ring_waddr(ring_waddr),
    .ring_wdata(ring_wdata),
    .ring_re   (ring_re),
    .ring_raddr(ring_raddr),
    .flags     (flags)
  );

  apsu_ring #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_waddr),
    .wdata(ring_wdata),
    .re   (ring_re),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

  // The ring read data register only changes on a new read, so it stays
  // valid for as long as the read stage is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_v <= s_tvalid;
      end
      if (s1_adv) begin
        out_v <= s1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags    <= flags;
      s1_fwd_data <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (s1_adv && s1_v) begin
      if (!s1_flags.valid) begin
        out_sample <= '0;
      end else if (s1_flags.fwd) begin
        out_sample <= s1_fwd_data;
      end else begin
        out_sample <= ring_rdata;
      end
      out_valid_bit <= s1_flags.valid;
      out_cend      <= s1_flags.cend;
      out_ovf       <= s1_flags.ovf;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = TDATA_W'(out_sample);
  assign m_tuser  = {out_ovf, out_valid_bit};
  assign m_tlast  = out_cend;

endmodule

// ===== src/apsu_checker.sv =====
// Port-level checker for the pause shortener, bound to its top level.
`timescale 1ns / 1ps
`include "audio_pause_shortener_unit_assert.svh"

module apsu_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  input logic [1:0]                       m_tuser
);

  // Reset empties the output register.
  `APSU_ASSERT_ALWAYS(a_reset_empties, rst |=> !m_tvalid, "result shown right after reset")

  // A result without a drained sample carries a zero sample.
  `APSU_ASSERT(a_idle_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0), "nonzero empty sample")

  // With the output register empty the input side must be open.
  `APSU_ASSERT(a_no_bubble, !m_tvalid |-> s_tready, "input blocked with empty output")

  // A stalled result holds.
  `APSU_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind audio_pause_shortener_unit apsu_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_apsu_checker (.*);
